// ===== rtl/njd_pkg.sv =====
// Shared constants, types and layer-size helpers for the neuron job dispatcher.
`timescale 1ns / 1ps
`default_nettype none

package njd_pkg;

    // Fixed field widths of the item and result channels.
    localparam int KIND_W    = 2;
    localparam int CORE_W    = 2;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = 10;
    localparam int ADDR_W    = 16;
    localparam int HID_W     = 3;
    localparam int LAYER_W   = 3;
    localparam int CFG_IDX_W = 3;

    // Default pool size; the core index field limits it to the range 1 to 4.
    localparam int CORES_DEF = 4;

    // Hidden layer slots provided by the configuration registers.
    localparam int HIDDEN_SLOTS = 4;
    localparam int SLOT_W       = $clog2(HIDDEN_SLOTS);

    // The weight area starts this far above address zero, plus the hidden count.
    localparam int BASE_OFFSET = 3;

    // Input item kinds.
    localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESULT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd3;

    // Result item kinds.
    localparam logic [KIND_W-1:0] RES_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] RES_JOB   = 2'd1;
    localparam logic [KIND_W-1:0] RES_WRITE = 2'd2;
    localparam logic [KIND_W-1:0] RES_DONE  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_LAYERS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_A      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_B      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_C      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_D      = 3'd6;

    typedef struct packed {
        logic [CNT_W-1:0]                     input_count;
        logic [CNT_W-1:0]                     output_count;
        logic [HIDDEN_SLOTS-1:0][CNT_W-1:0]   hidden_size;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic sum_step;
        logic exec;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sum_last;
    } t_stat;

    // Hidden layer counts above the number of slots count as the full number.
    function automatic logic [HID_W-1:0] clamp_hidden(input logic [HID_W-1:0] raw);
        logic [HID_W-1:0] lim;
        lim = HID_W'(HIDDEN_SLOTS);
        return (raw > lim) ? lim : raw;
    endfunction

    // Size of layer k: zero is the input layer, h+1 the output layer, anything
    // beyond that has no neurons.
    function automatic logic [CNT_W-1:0] layer_size(input logic [LAYER_W-1:0] k,
                                                    input logic [HID_W-1:0]   h,
                                                    input t_cfg               cfg);
        logic [LAYER_W:0]  last;
        logic [SLOT_W-1:0] slot;
        last = {1'b0, h} + {{LAYER_W{1'b0}}, 1'b1};
        slot = SLOT_W'(k - {{(LAYER_W-1){1'b0}}, 1'b1});
        if (k == '0) begin
            return cfg.input_count;
        end else if ({1'b0, k} == last) begin
            return cfg.output_count;
        end else if (k <= h) begin
            return cfg.hidden_size[slot];
        end else begin
            return '0;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/neuron_job_dispatcher.sv =====
// Top level of the neuron job dispatcher: hands perceptron neurons to a pool of worker cores.
// Dispatch tick, core result and core free items are first captured, then executed against
// the core table, which loads the result register. For a start item the shared 10x10
// multiplier adds one product of adjacent layer sizes per cycle, up to the output layer set
// by hidden_layers capped at four, before the start update. Every item yields
// exactly one result transfer; the final step waits while an earlier result is stalled.
// Reset (synchronous, active low) restores the register defaults, clears the counters and
// marks all cores free; the per-core destination table is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module neuron_job_dispatcher #(
    parameter int CORES = njd_pkg::CORES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // Item channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [njd_pkg::KIND_W-1:0]      i_kind,
    input  logic [njd_pkg::CORE_W-1:0]      i_core_index,
    input  logic [njd_pkg::DATA_W-1:0]      i_core_value,

    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [njd_pkg::KIND_W-1:0]      o_result_kind,
    output logic [njd_pkg::CORE_W-1:0]      o_job_core,
    output logic [njd_pkg::CNT_W-1:0]       o_job_count,
    output logic [njd_pkg::ADDR_W-1:0]      o_weight_address,
    output logic [njd_pkg::ADDR_W-1:0]      o_value_address,
    output logic [njd_pkg::ADDR_W-1:0]      o_target_address,
    output logic [njd_pkg::DATA_W-1:0]      o_write_data,

    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [njd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [njd_pkg::CNT_W-1:0]       i_cfg_data
);
    import njd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Configuration registers take a write in any cycle; they are expected to
    // change only while no item is in flight.
    assign o_cfg_ready = 1'b1;

    // The controller sequences each item: capture, then either the layer product
    // sweep followed by the start update, or a single execute step. It holds the
    // execute step or start update while the result register is still waiting to be taken, so a
    // stalled result never gets overwritten.
    njd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // The datapath holds the configuration, the weight and value pointers, the
    // layer and neuron counters, the busy marks and destinations of the cores,
    // and the result register that drives the output fields.
    njd_dpath #(
        .CORES (CORES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_kind           (i_kind),
        .i_core_index     (i_core_index),
        .i_core_value     (i_core_value),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_result_kind    (o_result_kind),
        .o_job_core       (o_job_core),
        .o_job_count      (o_job_count),
        .o_weight_address (o_weight_address),
        .o_value_address  (o_value_address),
        .o_target_address (o_target_address),
        .o_write_data     (o_write_data)
    );

endmodule

`default_nettype wire

// ===== rtl/njd_ctrl.sv =====
// Sequencing state machine of the neuron job dispatcher.
`timescale 1ns / 1ps
`default_nettype none

module njd_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [njd_pkg::KIND_W-1:0]  i_kind,
    input  logic                        i_out_stall,
    input  njd_pkg::t_stat              i_stat,
    output njd_pkg::t_cmd               o_cmd,
    output logic                        o_in_stall,
    output logic                        o_out_valid
);
    import njd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       slot_free;

    // The result register can be loaded when empty or when it is being taken.
    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = (i_kind == KIND_START) ? ST_SUM : ST_EXEC;
                end
            end
            ST_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_stat.sum_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_EXEC: begin
                if (slot_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_FIN: begin
                if (slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
        endcase
    end

    assign n_out_valid = o_cmd.exec || o_cmd.finish || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    a_item_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_kind != KIND_START) |=> (r_state == ST_EXEC))
        else $error("non-start item did not move to execute");

    a_sum_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM && i_stat.sum_last) |=> (r_state == ST_FIN))
        else $error("layer sum did not finish after its last step");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_EXEC || $past(r_state) == ST_FIN))
        else $error("result appeared outside execute or finish");

endmodule

`default_nettype wire

// ===== rtl/njd_dpath.sv =====
// Datapath of the neuron job dispatcher: configuration, counters, core table, result register.
`timescale 1ns / 1ps
`default_nettype none

module njd_dpath #(
    parameter int CORES = njd_pkg::CORES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  njd_pkg::t_cmd                   i_cmd,
    output njd_pkg::t_stat                  o_stat,
    input  logic [njd_pkg::KIND_W-1:0]      i_kind,
    input  logic [njd_pkg::CORE_W-1:0]      i_core_index,
    input  logic [njd_pkg::DATA_W-1:0]      i_core_value,
    input  logic                            i_cfg_valid,
    input  logic [njd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [njd_pkg::CNT_W-1:0]       i_cfg_data,
    output logic [njd_pkg::KIND_W-1:0]      o_result_kind,
    output logic [njd_pkg::CORE_W-1:0]      o_job_core,
    output logic [njd_pkg::CNT_W-1:0]       o_job_count,
    output logic [njd_pkg::ADDR_W-1:0]      o_weight_address,
    output logic [njd_pkg::ADDR_W-1:0]      o_value_address,
    output logic [njd_pkg::ADDR_W-1:0]      o_target_address,
    output logic [njd_pkg::DATA_W-1:0]      o_write_data
);
    import njd_pkg::*;

    localparam int CW = (CORES > 1) ? $clog2(CORES) : 1;

    // Configuration registers.
    t_cfg               r_cfg;
    logic [HID_W-1:0]   r_hidden;

    // Captured item.
    logic [KIND_W-1:0]  r_kind;
    logic [CORE_W-1:0]  r_core;
    logic [DATA_W-1:0]  r_value;

    // Layer product accumulation.
    logic [LAYER_W-1:0] r_k;
    logic [ADDR_W-1:0]  r_acc;

    // Run state.
    logic               r_running;
    logic [LAYER_W-1:0] r_layer;
    logic [CNT_W-1:0]   r_neuron;
    logic [ADDR_W-1:0]  r_wbase;
    logic [ADDR_W-1:0]  r_vbase;
    logic [CORES-1:0]   r_busy;
    logic [ADDR_W-1:0]  r_dest [0:CORES-1];

    // Result register.
    logic [KIND_W-1:0]  r_res_kind;
    logic [CORE_W-1:0]  r_res_core;
    logic [CNT_W-1:0]   r_res_count;
    logic [ADDR_W-1:0]  r_res_weight;
    logic [ADDR_W-1:0]  r_res_value;
    logic [ADDR_W-1:0]  r_res_target;
    logic [DATA_W-1:0]  r_res_data;

    logic [KIND_W-1:0]  n_res_kind;
    logic [CORE_W-1:0]  n_res_core;
    logic [CNT_W-1:0]   n_res_count;
    logic [ADDR_W-1:0]  n_res_weight;
    logic [ADDR_W-1:0]  n_res_value;
    logic [ADDR_W-1:0]  n_res_target;
    logic [DATA_W-1:0]  n_res_data;

    logic [HID_W-1:0]     h;
    logic [LAYER_W-1:0]   last;
    logic [CNT_W-1:0]     size_k;
    logic [CNT_W-1:0]     size_k1;
    logic [2*CNT_W-1:0]   product;
    logic [CNT_W-1:0]     cnt;
    logic [CNT_W-1:0]     next_size;
    logic [ADDR_W-1:0]    dest;
    logic [ADDR_W-1:0]    start_wbase;
    logic [CNT_W-1:0]     nidx;
    logic                 layer_done;
    logic                 found;
    logic [CW-1:0]        pick;
    logic                 core_ok;
    logic [CW-1:0]        cidx;
    logic                 can_issue;
    logic                 can_done;
    logic                 issue;

    assign h       = clamp_hidden(r_hidden);
    assign last    = LAYER_W'(h) + {{(LAYER_W-1){1'b0}}, 1'b1};

    // One product of adjacent layer sizes per step.
    assign size_k  = layer_size(r_k, h, r_cfg);
    assign size_k1 = layer_size(r_k + {{(LAYER_W-1){1'b0}}, 1'b1}, h, r_cfg);
    assign product = (2*CNT_W)'(size_k) * (2*CNT_W)'(size_k1);
    assign o_stat.sum_last = (r_k == LAYER_W'(h));

    assign start_wbase = ADDR_W'(h) + ADDR_W'(BASE_OFFSET);

    // Neuron issue arithmetic.
    assign cnt        = layer_size(r_layer, h, r_cfg);
    assign next_size  = layer_size(r_layer + {{(LAYER_W-1){1'b0}}, 1'b1}, h, r_cfg);
    assign dest       = r_vbase + ADDR_W'(cnt) + ADDR_W'(r_neuron);
    assign nidx       = r_neuron + {{(CNT_W-1){1'b0}}, 1'b1};
    assign layer_done = (nidx >= next_size) || (nidx == '0);

    // Highest-numbered free core wins.
    always_comb begin
        found = 1'b0;
        pick  = '0;
        for (int i = 0; i < CORES; i++) begin
            if (!r_busy[i]) begin
                found = 1'b1;
                pick  = CW'(i);
            end
        end
    end

    assign core_ok   = (5'(r_core) < 5'(CORES));
    assign cidx      = r_core[CW-1:0];
    assign can_issue = r_running && (r_layer < last) && found;
    assign can_done  = r_running && !(r_layer < last) && !(|r_busy);
    assign issue     = i_cmd.exec && (r_kind == KIND_TICK) && can_issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.input_count  <= CNT_W'(1);
            r_cfg.output_count <= CNT_W'(1);
            r_cfg.hidden_size  <= {HIDDEN_SLOTS{CNT_W'(1)}};
            r_hidden           <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_INPUT_COUNT:   r_cfg.input_count    <= i_cfg_data;
                REG_OUTPUT_COUNT:  r_cfg.output_count   <= i_cfg_data;
                REG_HIDDEN_LAYERS: r_hidden             <= i_cfg_data[HID_W-1:0];
                REG_HIDDEN_A:      r_cfg.hidden_size[0] <= i_cfg_data;
                REG_HIDDEN_B:      r_cfg.hidden_size[1] <= i_cfg_data;
                REG_HIDDEN_C:      r_cfg.hidden_size[2] <= i_cfg_data;
                REG_HIDDEN_D:      r_cfg.hidden_size[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_core  <= i_core_index;
            r_value <= i_core_value;
            r_k     <= '0;
            r_acc   <= '0;
        end else if (i_cmd.sum_step) begin
            r_k     <= r_k + {{(LAYER_W-1){1'b0}}, 1'b1};
            r_acc   <= r_acc + product[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_layer   <= '0;
            r_neuron  <= '0;
            r_wbase   <= '0;
            r_vbase   <= '0;
            r_busy    <= '0;
        end else if (i_cmd.finish) begin
            r_running <= 1'b1;
            r_layer   <= '0;
            r_neuron  <= '0;
            r_wbase   <= start_wbase;
            r_vbase   <= start_wbase + r_acc;
        end else if (i_cmd.exec) begin
            unique case (r_kind) inside
                KIND_TICK: begin
                    if (can_issue) begin
                        r_wbase      <= r_wbase + ADDR_W'(cnt);
                        r_busy[pick] <= 1'b1;
                        if (layer_done) begin
                            r_vbase  <= r_vbase + ADDR_W'(cnt);
                            r_neuron <= '0;
                            r_layer  <= r_layer + {{(LAYER_W-1){1'b0}}, 1'b1};
                        end else begin
                            r_neuron <= nidx;
                        end
                    end else if (can_done) begin
                        r_running <= 1'b0;
                    end
                end
                KIND_FREE: begin
                    if (core_ok) begin
                        r_busy[cidx] <= 1'b0;
                    end
                end
                KIND_START, KIND_RESULT: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_dest[pick] <= dest;
        end
    end

    always_comb begin
        n_res_kind   = RES_NONE;
        n_res_core   = '0;
        n_res_count  = '0;
        n_res_weight = '0;
        n_res_value  = '0;
        n_res_target = '0;
        n_res_data   = '0;
        if (i_cmd.exec) begin
            unique case (r_kind) inside
                KIND_TICK: begin
                    if (can_issue) begin
                        n_res_kind   = RES_JOB;
                        n_res_core   = CORE_W'(pick);
                        n_res_count  = cnt;
                        n_res_weight = r_wbase;
                        n_res_value  = r_vbase;
                        n_res_target = dest;
                    end else if (can_done) begin
                        n_res_kind   = RES_DONE;
                        n_res_target = r_vbase;
                    end
                end
                KIND_RESULT: begin
                    if (core_ok) begin
                        n_res_kind   = RES_WRITE;
                        n_res_core   = r_core;
                        n_res_target = r_dest[cidx];
                        n_res_data   = r_value;
                    end
                end
                KIND_START, KIND_FREE: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec || i_cmd.finish) begin
            r_res_kind   <= n_res_kind;
            r_res_core   <= n_res_core;
            r_res_count  <= n_res_count;
            r_res_weight <= n_res_weight;
            r_res_value  <= n_res_value;
            r_res_target <= n_res_target;
            r_res_data   <= n_res_data;
        end
    end

    assign o_result_kind    = r_res_kind;
    assign o_job_core       = r_res_core;
    assign o_job_count      = r_res_count;
    assign o_weight_address = r_res_weight;
    assign o_value_address  = r_res_value;
    assign o_target_address = r_res_target;
    assign o_write_data     = r_res_data;

    a_layer_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_layer <= LAYER_W'(HIDDEN_SLOTS + 1))
        else $error("layer counter ran past the output layer");

    a_issue_marks_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> ($countones(r_busy) == $past($countones(r_busy)) + 1))
        else $error("issued job did not mark exactly one more core busy");

endmodule

`default_nettype wire

// ===== sim/tb_neuron_job_dispatcher.sv =====
// Self-checking testbench for the neuron job dispatcher, with its own prediction of every result.
`timescale 1ns / 1ps

module tb_neuron_job_dispatcher;

    import njd_pkg::*;

    localparam int NUM_CORES = CORES_DEF;

    // One item on the input channel and one result on the output channel, at port widths.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CORE_W-1:0] core;
        logic [DATA_W-1:0] value;
    } t_job_item;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CORE_W-1:0] core;
        logic [CNT_W-1:0]  count;
        logic [ADDR_W-1:0] weight;
        logic [ADDR_W-1:0] value_addr;
        logic [ADDR_W-1:0] target;
        logic [DATA_W-1:0] data;
    } t_dispatch_result;

    // Every input of the block holds a known value from time zero.
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [KIND_W-1:0]    i_kind = KIND_TICK;
    logic [CORE_W-1:0]    i_core_index = '0;
    logic [DATA_W-1:0]    i_core_value = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [KIND_W-1:0]    o_result_kind;
    logic [CORE_W-1:0]    o_job_core;
    logic [CNT_W-1:0]     o_job_count;
    logic [ADDR_W-1:0]    o_weight_address;
    logic [ADDR_W-1:0]    o_value_address;
    logic [ADDR_W-1:0]    o_target_address;
    logic [DATA_W-1:0]    o_write_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_INPUT_COUNT;
    logic [CNT_W-1:0]     i_cfg_data = '0;

    neuron_job_dispatcher #(
        .CORES(NUM_CORES)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_core_index     (i_core_index),
        .i_core_value     (i_core_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_kind    (o_result_kind),
        .o_job_core       (o_job_core),
        .o_job_count      (o_job_count),
        .o_weight_address (o_weight_address),
        .o_value_address  (o_value_address),
        .o_target_address (o_target_address),
        .o_write_data     (o_write_data),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Items waiting to be offered, and the results that accepted items are owed.
    t_job_item        pending_items[$];
    t_dispatch_result expected_results[$];
    int unsigned      mismatch_count = 0;

    // Shadow copy of the layer configuration, updated on each accepted register write.
    logic [CNT_W-1:0] cfg_inputs = 10'd1;
    logic [CNT_W-1:0] cfg_outputs = 10'd1;
    logic [HID_W-1:0] cfg_hidden = '0;
    logic [CNT_W-1:0] cfg_hidden_size [HIDDEN_SLOTS] = '{default: 10'd1};

    // Shadow copy of the dispatcher state.
    logic                 net_running = 1'b0;
    logic [LAYER_W-1:0]   layer_idx = '0;
    logic [CNT_W-1:0]     neuron_idx = '0;
    logic [ADDR_W-1:0]    weight_ptr = '0;
    logic [ADDR_W-1:0]    value_ptr = '0;
    logic [NUM_CORES-1:0] core_busy = '0;
    int unsigned          busy_total = 0;
    logic [ADDR_W-1:0]    core_dest [NUM_CORES] = '{default: '0};

    // A hidden layer count above the number of slots behaves as the full number of slots.
    function automatic int unsigned hidden_used();
        return (cfg_hidden > HIDDEN_SLOTS) ? HIDDEN_SLOTS : int'(cfg_hidden);
    endfunction

    // Layer 0 is the input layer and layer h+1 the output layer; beyond that there is nothing.
    function automatic int unsigned layer_neurons(input int unsigned k);
        int unsigned h;
        h = hidden_used();
        if (k == 0) return cfg_inputs;
        if (k == h + 1) return cfg_outputs;
        if (k >= 1 && k <= h) return cfg_hidden_size[k-1];
        return 0;
    endfunction

    // Works out the single result that an accepted item produces and advances the shadow state.
    function automatic t_dispatch_result predict_dispatch(input t_job_item it);
        t_dispatch_result r;
        int unsigned      h;
        int unsigned      sum;
        int unsigned      cnt;
        int unsigned      dest;
        int unsigned      pick;
        int unsigned      k;
        r = '0;
        h = hidden_used();
        case (it.kind)
            KIND_START: begin
                // The products of adjacent layer sizes are summed in 32 bits, then wrapped.
                sum = 0;
                for (k = 0; k <= h; k++) begin
                    sum += layer_neurons(k) * layer_neurons(k + 1);
                end
                weight_ptr  = ADDR_W'(BASE_OFFSET + h);
                value_ptr   = ADDR_W'(weight_ptr + sum);
                layer_idx   = '0;
                neuron_idx  = '0;
                net_running = 1'b1;
            end
            KIND_TICK: begin
                if (!net_running) begin
                    // Nothing to hand out while no network is running.
                end else if (layer_idx < h + 1) begin
                    // The highest-numbered free core wins the job.
                    pick = NUM_CORES;
                    for (k = 0; k < NUM_CORES; k++) begin
                        if (!core_busy[k]) pick = k;
                    end
                    if (pick < NUM_CORES) begin
                        cnt  = layer_neurons(layer_idx);
                        dest = value_ptr + cnt + neuron_idx;
                        core_dest[pick] = ADDR_W'(dest);
                        r.kind       = RES_JOB;
                        r.core       = CORE_W'(pick);
                        r.count      = CNT_W'(cnt);
                        r.weight     = weight_ptr;
                        r.value_addr = value_ptr;
                        r.target     = ADDR_W'(dest);
                        weight_ptr   = ADDR_W'(weight_ptr + cnt);
                        neuron_idx   = CNT_W'(neuron_idx + 1);
                        // A layer is complete once the count reaches or passes the next size.
                        if (neuron_idx >= layer_neurons(layer_idx + 1) || neuron_idx == 0) begin
                            value_ptr  = ADDR_W'(value_ptr + cnt);
                            neuron_idx = '0;
                            layer_idx  = LAYER_W'(layer_idx + 1);
                        end
                        core_busy[pick] = 1'b1;
                        busy_total++;
                    end
                end else if (busy_total == 0) begin
                    r.kind      = RES_DONE;
                    r.target    = value_ptr;
                    net_running = 1'b0;
                end
            end
            KIND_RESULT: begin
                r.kind   = RES_WRITE;
                r.core   = it.core;
                r.target = core_dest[it.core];
                r.data   = it.value;
            end
            KIND_FREE: begin
                if (core_busy[it.core]) begin
                    core_busy[it.core] = 1'b0;
                    if (busy_total > 0) busy_total--;
                end
            end
        endcase
        return r;
    endfunction

    // 100 MHz clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Sender: takes items from the pending queue and offers them in bursts of random length,
    // with random gaps between bursts. A gap of zero joins two bursts into one long stretch.
    int unsigned gap_left = 0;
    int unsigned burst_left = 0;
    t_job_item   next_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   = 0;
            burst_left = 0;
        end else begin
            // A transfer at this edge: the item is now owed exactly one result.
            if (i_in_valid && !o_in_stall) begin
                expected_results = {expected_results,
                                    predict_dispatch({i_kind, i_core_index, i_core_value})};
            end
            // The payload may only change once the current item has gone.
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    next_item = pending_items.pop_front();
                    i_in_valid   <= 1'b1;
                    i_kind       <= next_item.kind;
                    i_core_index <= next_item.core;
                    i_core_value <= next_item.value;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure: every so often a new mode is chosen among no stall at all,
    // stalls drawn at random in each cycle, and alternating runs of stall and flow.
    int unsigned stall_mode = 0;
    int unsigned mode_cycles = 0;
    int unsigned run_left = 0;
    logic        run_level = 1'b0;
    logic        stall_next;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (mode_cycles == 0) begin
                stall_mode  = $urandom_range(0, 2);
                mode_cycles = $urandom_range(64, 256);
            end else begin
                mode_cycles--;
            end
            case (stall_mode)
                0: stall_next = 1'b0;
                1: stall_next = ($urandom_range(0, 9) < 3);
                default: begin
                    if (run_left == 0) begin
                        run_left  = $urandom_range(1, 12);
                        run_level = ~run_level;
                    end
                    run_left--;
                    stall_next = run_level;
                end
            endcase
            i_out_stall <= stall_next;
        end
    end

    // Monitor: each result transfer is compared with the oldest expectation.
    t_dispatch_result seen;
    t_dispatch_result owed;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = {o_result_kind, o_job_core, o_job_count, o_weight_address,
                    o_value_address, o_target_address, o_write_data};
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: result with nothing outstanding: kind=%0d core=%0d",
                             $realtime, seen.kind, seen.core);
                end
            end else begin
                owed = expected_results.pop_front();
                if (seen !== owed) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: result differs", $realtime);
                        $display("  expected kind=%0d core=%0d count=%0d w=%h v=%h t=%h d=%h",
                                 owed.kind, owed.core, owed.count, owed.weight,
                                 owed.value_addr, owed.target, owed.data);
                        $display("  actual   kind=%0d core=%0d count=%0d w=%h v=%h t=%h d=%h",
                                 seen.kind, seen.core, seen.count, seen.weight,
                                 seen.value_addr, seen.target, seen.data);
                    end
                end
            end
        end
    end

    task automatic queue_item(input logic [KIND_W-1:0] kind, input int unsigned core,
                              input logic [DATA_W-1:0] value);
        t_job_item it;
        it = {kind, CORE_W'(core), value};
        pending_items = {pending_items, it};
    endtask

    // One register write; valid stays high so that the next write follows without a gap.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CNT_W'(data);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_INPUT_COUNT:   cfg_inputs  = CNT_W'(data);
            REG_OUTPUT_COUNT:  cfg_outputs = CNT_W'(data);
            REG_HIDDEN_LAYERS: cfg_hidden  = HID_W'(data);
            REG_HIDDEN_A:      cfg_hidden_size[0] = CNT_W'(data);
            REG_HIDDEN_B:      cfg_hidden_size[1] = CNT_W'(data);
            REG_HIDDEN_C:      cfg_hidden_size[2] = CNT_W'(data);
            REG_HIDDEN_D:      cfg_hidden_size[3] = CNT_W'(data);
            default: ;
        endcase
    endtask

    // Writes the whole layer configuration; only called while the block is idle.
    task automatic apply_config(input int unsigned in_c, input int unsigned out_c,
                                input int unsigned hid, input int unsigned sa,
                                input int unsigned sb, input int unsigned sc,
                                input int unsigned sd);
        write_reg(REG_INPUT_COUNT, in_c);
        write_reg(REG_OUTPUT_COUNT, out_c);
        write_reg(REG_HIDDEN_LAYERS, hid);
        write_reg(REG_HIDDEN_A, sa);
        write_reg(REG_HIDDEN_B, sb);
        write_reg(REG_HIDDEN_C, sc);
        write_reg(REG_HIDDEN_D, sd);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every pending item has been sent and every owed result has arrived, then lets the block settle.
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
    endtask

    // Mostly small layers, now and then an empty one.
    function automatic int unsigned small_size();
        return ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
    endfunction

    initial begin
        int unsigned random_items;
        int unsigned phase;
        int unsigned mode;
        int unsigned n;
        int unsigned roll;
        int unsigned i;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A 1023-wide input layer feeding six outputs, so that every core gets
        // a job before any core result is sent: no result may name a core whose destination
        // was never recorded.
        apply_config(1023, 6, 0, 0, 1023, 1, 512);
        queue_item(KIND_TICK, 0, '0);                  // tick while no network runs
        queue_item(KIND_START, 3, 32'hFFFF_FFFF);
        repeat (4) queue_item(KIND_TICK, 0, '0);       // jobs to cores 3, 2, 1, 0
        queue_item(KIND_TICK, 0, '0);                  // no free core
        queue_item(KIND_RESULT, 0, 32'h0000_0000);
        queue_item(KIND_RESULT, 3, 32'hFFFF_FFFF);
        queue_item(KIND_RESULT, 1, 32'hAAAA_5555);
        queue_item(KIND_RESULT, 2, 32'h5555_AAAA);
        queue_item(KIND_FREE, 2, '0);
        queue_item(KIND_FREE, 2, '0);                  // core already free: ignored
        queue_item(KIND_TICK, 0, '0);                  // job to core 2
        queue_item(KIND_FREE, 1, '0);
        queue_item(KIND_TICK, 0, '0);                  // last neuron of the layer, core 1
        queue_item(KIND_TICK, 0, '0);                  // all issued, cores still busy
        for (i = 0; i < NUM_CORES; i++) queue_item(KIND_FREE, i, '0);
        queue_item(KIND_TICK, 0, '0);                  // network done
        queue_item(KIND_TICK, 0, '0);                  // tick after done
        wait_drained();

        // Random part, in phases. Each phase rewrites the configuration while the block is
        // idle. A phase that does not open with a start carries on the previous network under
        // the new sizes, which exercises the live reading of the registers.
        random_items = 0;
        phase = 0;
        while (random_items < 600) begin
            mode = phase % 7;
            case (mode)
                1: apply_config(1023, 1023, 4, 1023, 1023, 1023, 1023);
                3: apply_config(0, 0, $urandom_range(0, 4), 0, 0, 0, 0);
                5: apply_config(small_size(), small_size(), $urandom_range(5, 7),
                                small_size(), small_size(), small_size(), small_size());
                6: apply_config(1, 1, 0, 1, 1, 1, 1);
                default: apply_config(small_size(), small_size(), $urandom_range(0, 4),
                                      small_size(), small_size(), small_size(),
                                      small_size());
            endcase
            n = (mode == 1) ? 30 : $urandom_range(35, 60);
            if ($urandom_range(0, 3) != 0) queue_item(KIND_START, $urandom_range(0, 3),
                                                      $urandom());
            for (i = 0; i < n; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 6) begin
                    queue_item(KIND_START, $urandom_range(0, 3), $urandom());
                end else if (roll < 52) begin
                    queue_item(KIND_TICK, $urandom_range(0, 3), $urandom());
                end else if (roll < 80) begin
                    queue_item(KIND_FREE, $urandom_range(0, 3), $urandom());
                end else begin
                    queue_item(KIND_RESULT, $urandom_range(0, 3), $urandom());
                end
            end
            random_items += n;
            phase++;
            wait_drained();
        end

        mismatch_count += expected_results.size();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: reports a failure and ends the run if the test has not finished first.
    initial begin
        #(3_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== neuron_job_dispatcher.f =====
rtl/njd_pkg.sv
rtl/njd_ctrl.sv
rtl/njd_dpath.sv
rtl/neuron_job_dispatcher.sv
sim/tb_neuron_job_dispatcher.sv
